FILE: rtl/crb_pkg.sv
package crb_pkg;

  // Field widths fixed by the interface.
  localparam int XW       = 24;
  localparam int VALW     = 32;
  localparam int CNTW_OUT = 6;
  localparam int TOLW     = 16;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_COEF_CUBE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_SQUARE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_LINEAR = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_CONST  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE   = 3'd4;

  // Register reset values.
  localparam logic signed [XW-1:0] RST_COEF_CUBE   = 24'sd131072;
  localparam logic signed [XW-1:0] RST_COEF_SQUARE = -24'sd65536;
  localparam logic signed [XW-1:0] RST_COEF_LINEAR = 24'sd1310720;
  localparam logic signed [XW-1:0] RST_COEF_CONST  = -24'sd3276800;
  localparam logic [TOLW-1:0]      RST_TOLERANCE   = 16'd66;

  // Horner accumulator: saturates to [-2^39, 2^39], so 41 bits signed.
  localparam int ACCW  = 41;
  // The accumulator is multiplied in two pieces: low 20 bits and high 21 bits.
  localparam int LO_W  = 20;
  localparam int HI_W  = ACCW - LO_W;
  localparam int MULW  = HI_W + XW;
  localparam int PRODW = MULW + LO_W;

  localparam logic signed [PRODW-1:0] ACC_MAX = 65'sh0_0000_0080_0000_0000;
  localparam logic signed [PRODW-1:0] ACC_MIN = -65'sh0_0000_0080_0000_0000;

  localparam logic signed [ACCW-1:0] VAL_MAX = 41'sd2147483647;
  localparam logic signed [ACCW-1:0] VAL_MIN = -41'sd2147483648;

  typedef struct packed {
    logic signed [XW-1:0] left_bound;
    logic signed [XW-1:0] right_bound;
  } in_t;

  typedef struct packed {
    logic signed [XW-1:0]   root;
    logic signed [VALW-1:0] value_at_root;
    logic [CNTW_OUT-1:0]    iteration_count;
    logic                   hit_limit;
  } out_t;

  typedef struct packed {
    logic signed [XW-1:0] coef_cube;
    logic signed [XW-1:0] coef_square;
    logic signed [XW-1:0] coef_linear;
    logic signed [XW-1:0] coef_const;
    logic [TOLW-1:0]      tolerance;
  } cfg_t;

  typedef enum logic [1:0] {
    COEF_SQUARE,
    COEF_LINEAR,
    COEF_CONST
  } coef_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      acc_init;
    logic      mul_lo_en;
    logic      mul_hi_en;
    logic      sum_en;
    logic      acc_en;
    coef_sel_t coef_sel;
    logic      save_sl;
    logic      mid;
    logic      update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv;
    logic go_left;
  } status_t;

endpackage

FILE: rtl/crb_dp.sv
module crb_dp #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                 clk,
  input  crb_pkg::cfg_t                        cfg,
  input  crb_pkg::in_t                         in_data,
  input  crb_pkg::cmd_t                        cmd,
  output crb_pkg::status_t                     status,
  output logic signed [crb_pkg::XW-1:0]        root,
  output logic signed [crb_pkg::ACCW-1:0]      acc_value
);

  // Bracket, midpoint and evaluation point.
  logic signed [crb_pkg::XW-1:0]    l;
  logic signed [crb_pkg::XW-1:0]    r;
  logic signed [crb_pkg::XW-1:0]    m;
  logic signed [crb_pkg::XW-1:0]    x;
  // Horner accumulator and partial products.
  logic signed [crb_pkg::ACCW-1:0]  acc;
  logic signed [crb_pkg::MULW-1:0]  p_lo;
  logic signed [crb_pkg::MULW-1:0]  p_hi;
  logic signed [crb_pkg::PRODW-1:0] prod;
  // Sign of the cubic at the left end.
  logic                             sl_zero;
  logic                             sl_neg;

  logic signed [crb_pkg::XW:0]      mid_sum;
  logic signed [crb_pkg::HI_W-1:0]  mul_a;
  logic signed [crb_pkg::MULW-1:0]  mul_out;
  logic signed [crb_pkg::PRODW-1:0] shifted;
  logic signed [crb_pkg::XW-1:0]    coef;
  logic signed [crb_pkg::PRODW-1:0] acc_sum;
  logic signed [crb_pkg::PRODW-1:0] acc_clamped;
  logic                             acc_zero;
  logic                             acc_neg;
  logic                             go_left;
  logic signed [crb_pkg::XW-1:0]    side;
  logic signed [crb_pkg::XW:0]      diff;
  logic [crb_pkg::XW:0]             gap;

  // Midpoint: floor of the half sum, taken from the 25 bit sum.
  assign mid_sum = {l[crb_pkg::XW-1], l} + {r[crb_pkg::XW-1], r};

  // Shared signed multiplier, used once for each half of the accumulator.
  assign mul_a   = cmd.mul_hi_en ? acc[crb_pkg::ACCW-1:crb_pkg::LO_W]
                                 : {1'b0, acc[crb_pkg::LO_W-1:0]};
  assign mul_out = mul_a * x;

  // Rescale the product, add the next coefficient and saturate.
  assign shifted = prod >>> FRACTION_BITS;

  always_comb begin
    case (cmd.coef_sel)
      crb_pkg::COEF_SQUARE: coef = cfg.coef_square;
      crb_pkg::COEF_LINEAR: coef = cfg.coef_linear;
      default:              coef = cfg.coef_const;
    endcase
  end

  assign acc_sum = shifted + {{(crb_pkg::PRODW-crb_pkg::XW){coef[crb_pkg::XW-1]}}, coef};

  always_comb begin
    if (acc_sum > crb_pkg::ACC_MAX) begin
      acc_clamped = crb_pkg::ACC_MAX;
    end else if (acc_sum < crb_pkg::ACC_MIN) begin
      acc_clamped = crb_pkg::ACC_MIN;
    end else begin
      acc_clamped = acc_sum;
    end
  end

  // Sign test: the midpoint value shares the nonzero sign of the left end.
  assign acc_zero = (acc == '0);
  assign acc_neg  = acc[crb_pkg::ACCW-1];
  assign go_left  = !acc_zero && !sl_zero && (acc_neg == sl_neg);

  // Distance from the midpoint to the end it would replace.
  assign side = go_left ? l : m;
  always_comb begin
    if (go_left) begin
      diff = {side[crb_pkg::XW-1], side} - {m[crb_pkg::XW-1], m};
    end else begin
      diff = {r[crb_pkg::XW-1], r} - {m[crb_pkg::XW-1], m};
    end
    gap = diff[crb_pkg::XW] ? '0 - diff : diff;
  end

  assign status.go_left = go_left;
  assign status.conv    = (gap < {{(crb_pkg::XW+1-crb_pkg::TOLW){1'b0}}, cfg.tolerance});

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      l <= in_data.left_bound;
      r <= in_data.right_bound;
      x <= in_data.left_bound;
    end
    if (cmd.mid) begin
      m <= mid_sum[crb_pkg::XW:1];
      x <= mid_sum[crb_pkg::XW:1];
    end
    if (cmd.update) begin
      if (go_left) begin
        l       <= m;
        sl_zero <= 1'b0;
        sl_neg  <= acc_neg;
      end else begin
        r <= m;
      end
    end
    if (cmd.save_sl) begin
      sl_zero <= acc_zero;
      sl_neg  <= acc_neg;
    end
    if (cmd.acc_init) begin
      acc <= {{(crb_pkg::ACCW-crb_pkg::XW){cfg.coef_cube[crb_pkg::XW-1]}}, cfg.coef_cube};
    end
    if (cmd.mul_lo_en) begin
      p_lo <= mul_out;
    end
    if (cmd.mul_hi_en) begin
      p_hi <= mul_out;
    end
    if (cmd.sum_en) begin
      prod <= {p_hi, {crb_pkg::LO_W{1'b0}}}
            + {{(crb_pkg::PRODW-crb_pkg::MULW){p_lo[crb_pkg::MULW-1]}}, p_lo};
    end
    if (cmd.acc_en) begin
      acc <= acc_clamped[crb_pkg::ACCW-1:0];
    end
  end

  assign root      = m;
  assign acc_value = acc;

endmodule

FILE: rtl/crb_ctrl.sv
module crb_ctrl #(
  parameter int MAX_ITERATIONS = 40,
  parameter int CNT_W          = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_free,
  input  crb_pkg::status_t status,
  output crb_pkg::cmd_t    cmd,
  output logic             in_ready,
  output logic             out_load,
  output logic [CNT_W-1:0] count,
  output logic             hit
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_ACC,
    S_SAVE_SL,
    S_MID,
    S_DECIDE,
    S_FINISH
  } state_t;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITERATIONS);

  state_t     state;
  logic [1:0] step;
  logic       eval_left;

  // Sequencer: cubic at the left end once, then one cubic per halving.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      hit       <= 1'b0;
      step      <= '0;
      eval_left <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            count     <= '0;
            eval_left <= 1'b1;
            state     <= S_INIT;
          end
        end
        S_INIT: begin
          step  <= '0;
          state <= S_MUL_LO;
        end
        S_MUL_LO: state <= S_MUL_HI;
        S_MUL_HI: state <= S_SUM;
        S_SUM:    state <= S_ACC;
        S_ACC: begin
          if (step == 2'd2) begin
            state <= eval_left ? S_SAVE_SL : S_DECIDE;
          end else begin
            step  <= step + 2'd1;
            state <= S_MUL_LO;
          end
        end
        S_SAVE_SL: begin
          eval_left <= 1'b0;
          state     <= S_MID;
        end
        S_MID: begin
          count <= count + 1'b1;
          state <= S_INIT;
        end
        S_DECIDE: begin
          if (status.conv) begin
            hit   <= 1'b0;
            state <= S_FINISH;
          end else if (count == CNT_MAX) begin
            hit   <= 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_MID;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath commands decoded from the state.
  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.acc_init  = (state == S_INIT);
    cmd.mul_lo_en = (state == S_MUL_LO);
    cmd.mul_hi_en = (state == S_MUL_HI);
    cmd.sum_en    = (state == S_SUM);
    cmd.acc_en    = (state == S_ACC);
    cmd.save_sl   = (state == S_SAVE_SL);
    cmd.mid       = (state == S_MID);
    cmd.update    = (state == S_DECIDE) && !status.conv;
    case (step)
      2'd0:    cmd.coef_sel = crb_pkg::COEF_SQUARE;
      2'd1:    cmd.coef_sel = crb_pkg::COEF_LINEAR;
      default: cmd.coef_sel = crb_pkg::COEF_CONST;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_FINISH) && out_free;

`ifndef SYNTH
  // The halving count never passes the cap.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("iteration count above cap");

  // A new halving only starts below the cap.
  a_mid_below_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_MID) |-> (count < CNT_MAX))
    else $error("halving started at the cap");

  // A result flagged as capped carries the full iteration count.
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (out_load && hit) |-> (count == CNT_MAX))
    else $error("cap flag without full count");

  // Horner step counter covers the three coefficients only.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> (step != 2'd3))
    else $error("Horner step out of range");
`endif

endmodule

FILE: rtl/cubic_root_bisection_core.sv
// Bisection root finder for a cubic with configurable coefficients.
// Input channel (in_valid/in_ready/in_data) takes one item: a starting bracket
// of two signed Q8.16 bounds. Output channel (out_valid/out_ready/out_data)
// returns one item per input: the final midpoint, the cubic there saturated to
// Q16.16, the number of halvings and a flag set when the iteration cap ended
// the search. Coefficients and tolerance are written through cfg_we, cfg_index
// and cfg_data; the user must do so only while the block is idle, which the
// block does not enforce itself; an unused index is ignored. One item is
// worked on at a time. The cubic is evaluated by Horner's rule on one shared
// 21x24 multiplier, each Horner step being two partial products, a sum and a
// rescale with saturation. The left end is evaluated once; each halving then
// forms the midpoint, evaluates the cubic there and decides. The iteration
// count is at most MAX_ITERATIONS. The result sits in an output register;
// in_ready rises again as soon as it is loaded, so the next item starts while
// the receiver stalls. If the previous result is still held, the finished
// item waits until that one is taken. Reset (rst, synchronous) empties the
// output register, stops any search and restores the default coefficients
// and tolerance.
module cubic_root_bisection_core #(
  parameter int MAX_ITERATIONS = 40,
  parameter int FRACTION_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  crb_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output crb_pkg::out_t                      out_data,
  input  logic                               cfg_we,
  input  logic [crb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [crb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);

  crb_pkg::cfg_t                     cfg;
  crb_pkg::cmd_t                     cmd;
  crb_pkg::status_t                  status;
  logic                              out_free;
  logic                              out_load;
  logic [CNT_W-1:0]                  count;
  logic                              hit;
  logic signed [crb_pkg::XW-1:0]     root;
  logic signed [crb_pkg::ACCW-1:0]   acc_value;
  logic [6:0]                        count_ext;
  logic [crb_pkg::CNTW_OUT-1:0]      count_sat;
  logic signed [crb_pkg::VALW-1:0]   value_sat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_cube   <= crb_pkg::RST_COEF_CUBE;
      cfg.coef_square <= crb_pkg::RST_COEF_SQUARE;
      cfg.coef_linear <= crb_pkg::RST_COEF_LINEAR;
      cfg.coef_const  <= crb_pkg::RST_COEF_CONST;
      cfg.tolerance   <= crb_pkg::RST_TOLERANCE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crb_pkg::REG_COEF_CUBE:   cfg.coef_cube   <= cfg_data;
        crb_pkg::REG_COEF_SQUARE: cfg.coef_square <= cfg_data;
        crb_pkg::REG_COEF_LINEAR: cfg.coef_linear <= cfg_data;
        crb_pkg::REG_COEF_CONST:  cfg.coef_const  <= cfg_data;
        crb_pkg::REG_TOLERANCE:   cfg.tolerance   <= cfg_data[crb_pkg::TOLW-1:0];
        default: ;
      endcase
    end
  end

  crb_ctrl #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .CNT_W          (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd),
    .in_ready (in_ready),
    .out_load (out_load),
    .count    (count),
    .hit      (hit)
  );

  crb_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .root      (root),
    .acc_value (acc_value)
  );

  // Saturate the value to 32 bits and the count to 6 bits.
  always_comb begin
    if (acc_value > crb_pkg::VAL_MAX) begin
      value_sat = crb_pkg::VAL_MAX[crb_pkg::VALW-1:0];
    end else if (acc_value < crb_pkg::VAL_MIN) begin
      value_sat = crb_pkg::VAL_MIN[crb_pkg::VALW-1:0];
    end else begin
      value_sat = acc_value[crb_pkg::VALW-1:0];
    end
    count_ext = 7'(count);
    count_sat = (count_ext > 7'd63) ? 6'd63 : count_ext[crb_pkg::CNTW_OUT-1:0];
  end

  // Output register: free when empty or being taken this cycle.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.root            <= root;
      out_data.value_at_root   <= value_sat;
      out_data.iteration_count <= count_sat;
      out_data.hit_limit       <= hit;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int     MAX_ITER       = 40;
  localparam int     FRAC_BITS      = 16;
  localparam int     ONE            = 1 << FRAC_BITS;
  localparam int     NARROW_SPAN    = 16 * ONE;
  localparam int     COEF_SPAN      = 8 * ONE;
  localparam int     RANDOM_PHASES  = 10;
  localparam int     PHASE_ITEMS    = 100;
  localparam int     TAIL_CYCLES    = 15 * MAX_ITER + 100;
  localparam int     CYCLE_LIMIT    = 3_000_000;
  localparam int     CFG_INDEX_LAST = (1 << crb_pkg::CFG_INDEX_W) - 1;
  localparam longint ACC_LIM        = longint'(1) << 39;
  localparam longint VAL_HI         = 2147483647;
  localparam longint VAL_LO         = -VAL_HI - 1;
  localparam logic [crb_pkg::XW-1:0] X_MAX = 24'h7FFFFF;
  localparam logic [crb_pkg::XW-1:0] X_MIN = 24'h800000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  crb_pkg::in_t                    in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  crb_pkg::out_t                   out_data;
  logic                            cfg_we = 1'b0;
  logic [crb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [crb_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Register copy used by the predictor.
  crb_pkg::cfg_t model_cfg = '{crb_pkg::RST_COEF_CUBE, crb_pkg::RST_COEF_SQUARE,
                               crb_pkg::RST_COEF_LINEAR, crb_pkg::RST_COEF_CONST,
                               crb_pkg::RST_TOLERANCE};

  crb_pkg::in_t  brackets[$];
  crb_pkg::out_t predicted_roots[$];
  int   items_queued = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   cap_hits = 0;
  int   settings_used = 1;
  int   cycles = 0;

  cubic_root_bisection_core #(
    .MAX_ITERATIONS(MAX_ITER),
    .FRACTION_BITS (FRAC_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial forever #4 clk = ~clk;

  function automatic longint sx24(logic [crb_pkg::XW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp_acc(longint v);
    if (v > ACC_LIM) return ACC_LIM;
    if (v < -ACC_LIM) return -ACC_LIM;
    return v;
  endfunction

  // Horner evaluation with a floor rescale and saturation after each step.
  function automatic longint cubic_at(longint x);
    longint acc;
    acc = sx24(model_cfg.coef_cube);
    acc = clamp_acc(((acc * x) >>> FRAC_BITS) + sx24(model_cfg.coef_square));
    acc = clamp_acc(((acc * x) >>> FRAC_BITS) + sx24(model_cfg.coef_linear));
    acc = clamp_acc(((acc * x) >>> FRAC_BITS) + sx24(model_cfg.coef_const));
    return acc;
  endfunction

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic bit closer_than_tol(longint a, longint b);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return d < longint'(model_cfg.tolerance);
  endfunction

  // Runs the whole bisection search for one bracket.
  function automatic crb_pkg::out_t bisect_cubic(crb_pkg::in_t br);
    longint        l, r, m, v;
    int            steps, sm, sl;
    bit            capped, done;
    crb_pkg::out_t res;
    l = sx24(br.left_bound);
    r = sx24(br.right_bound);
    m = 0;
    steps = 0;
    capped = 1'b1;
    done = 1'b0;
    while (!done && steps < MAX_ITER) begin
      steps++;
      m = (l + r) >>> 1;
      sm = sign_of(cubic_at(m));
      sl = sign_of(cubic_at(l));
      // Same nonzero sign at the midpoint and left end moves the left end.
      if (sm != 0 && sm == sl) begin
        if (closer_than_tol(l, m)) begin
          capped = 1'b0;
          done = 1'b1;
        end else begin
          l = m;
        end
      end else begin
        if (closer_than_tol(r, m)) begin
          capped = 1'b0;
          done = 1'b1;
        end else begin
          r = m;
        end
      end
    end
    v = cubic_at(m);
    if (v > VAL_HI) v = VAL_HI;
    if (v < VAL_LO) v = VAL_LO;
    if (steps > 63) steps = 63;
    res.root = m[crb_pkg::XW-1:0];
    res.value_at_root = v[crb_pkg::VALW-1:0];
    res.iteration_count = steps[crb_pkg::CNTW_OUT-1:0];
    res.hit_limit = capped;
    return res;
  endfunction

  function automatic logic [crb_pkg::XW-1:0] narrow_x(int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return v[crb_pkg::XW-1:0];
  endfunction

  function automatic logic [crb_pkg::XW-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return X_MAX;
      1: return X_MIN;
      2: return '0;
      3, 4: return crb_pkg::XW'($urandom());
      default: return narrow_x(COEF_SPAN);
    endcase
  endfunction

  function automatic logic [crb_pkg::TOLW-1:0] rand_tol();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return crb_pkg::TOLW'($urandom());
      default: return crb_pkg::TOLW'($urandom_range(1, 1024));
    endcase
  endfunction

  task automatic send_bracket(input logic [crb_pkg::XW-1:0] l,
                              input logic [crb_pkg::XW-1:0] r);
    brackets.push_back('{l, r});
    items_queued++;
  endtask

  // One register write; the predictor's copy follows it.
  task automatic write_reg(input logic [crb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [crb_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      crb_pkg::REG_COEF_CUBE:   model_cfg.coef_cube = data;
      crb_pkg::REG_COEF_SQUARE: model_cfg.coef_square = data;
      crb_pkg::REG_COEF_LINEAR: model_cfg.coef_linear = data;
      crb_pkg::REG_COEF_CONST:  model_cfg.coef_const = data;
      crb_pkg::REG_TOLERANCE:   model_cfg.tolerance = data[crb_pkg::TOLW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [crb_pkg::XW-1:0] cube,
                              input logic [crb_pkg::XW-1:0] square,
                              input logic [crb_pkg::XW-1:0] linear,
                              input logic [crb_pkg::XW-1:0] konst,
                              input logic [crb_pkg::TOLW-1:0] tol);
    write_reg(crb_pkg::REG_COEF_CUBE, cube);
    write_reg(crb_pkg::REG_COEF_SQUARE, square);
    write_reg(crb_pkg::REG_COEF_LINEAR, linear);
    write_reg(crb_pkg::REG_COEF_CONST, konst);
    write_reg(crb_pkg::REG_TOLERANCE, crb_pkg::CFG_DATA_W'(tol));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Waits until every queued bracket has produced its result.
  task automatic wait_drained();
    while (results_seen < items_queued) @(posedge clk);
    @(posedge clk);
  endtask

  // Input driver: one item per bracket, with a random gap after each.
  int  in_gap = 0;
  bit  in_calm = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) predicted_roots.push_back(bisect_cubic(in_data));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (brackets.size() > 0) begin
          in_data <= brackets.pop_front();
          in_valid <= 1'b1;
          in_gap = in_calm ? 0 : $urandom_range(0, 9);
          if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each result item and stalls at random after it.
  int            out_hold = 0;
  bit            out_calm = 1'b0;
  crb_pkg::out_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_roots.size() == 0) begin
          $error("result item with no bracket pending: root %0d", out_data.root);
          mismatches++;
        end else begin
          want = predicted_roots.pop_front();
          if (want.hit_limit) cap_hits++;
          if (out_data.root !== want.root) begin
            $error("root: expected %0d, got %0d", want.root, out_data.root);
            mismatches++;
          end
          if (out_data.value_at_root !== want.value_at_root) begin
            $error("value_at_root: expected %0d, got %0d",
                   want.value_at_root, out_data.value_at_root);
            mismatches++;
          end
          if (out_data.iteration_count !== want.iteration_count) begin
            $error("iteration_count: expected %0d, got %0d",
                   want.iteration_count, out_data.iteration_count);
            mismatches++;
          end
          if (out_data.hit_limit !== want.hit_limit) begin
            $error("hit_limit: expected %0d, got %0d", want.hit_limit, out_data.hit_limit);
            mismatches++;
          end
        end
        out_hold = out_calm ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    logic [crb_pkg::XW-1:0] a, b, t;
    int                     kind, tries;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset coefficients: ordinary, swapped, equal and extreme brackets.
    send_bracket('0, crb_pkg::XW'(5 * ONE));
    send_bracket(crb_pkg::XW'(5 * ONE), '0);
    send_bracket(crb_pkg::XW'(3 * ONE), crb_pkg::XW'(3 * ONE));
    send_bracket(X_MIN, X_MAX);
    send_bracket(X_MAX, X_MIN);
    send_bracket(X_MIN, X_MIN);
    send_bracket(X_MAX, X_MAX);
    send_bracket(crb_pkg::XW'(-1), '0);
    send_bracket(crb_pkg::XW'(2 * ONE + ONE / 2), crb_pkg::XW'(-7 * ONE));
    wait_drained();

    // f(x) = x: a zero at the midpoint and a zero at the left end.
    load_setting('0, '0, crb_pkg::XW'(ONE), '0, crb_pkg::TOLW'(1));
    send_bracket(crb_pkg::XW'(-4 * ONE), crb_pkg::XW'(4 * ONE));
    send_bracket('0, crb_pkg::XW'(4 * ONE));
    send_bracket(crb_pkg::XW'(-3 * ONE), crb_pkg::XW'(5 * ONE));
    wait_drained();

    // Writes to unused indexes must leave the setting unchanged.
    for (int idx = crb_pkg::REG_TOLERANCE + 1; idx <= CFG_INDEX_LAST; idx++)
      write_reg(idx[crb_pkg::CFG_INDEX_W-1:0], crb_pkg::CFG_DATA_W'($urandom()));
    @(posedge clk);
    cfg_we <= 1'b0;
    send_bracket(crb_pkg::XW'(-4 * ONE), crb_pkg::XW'(4 * ONE));
    wait_drained();

    // Zero tolerance never converges, so the search runs to the cap.
    load_setting(crb_pkg::RST_COEF_CUBE, crb_pkg::RST_COEF_SQUARE,
                 crb_pkg::RST_COEF_LINEAR, crb_pkg::RST_COEF_CONST, '0);
    send_bracket('0, crb_pkg::XW'(5 * ONE));
    send_bracket(X_MIN, X_MAX);
    wait_drained();

    // Extreme coefficients drive the accumulator and the value into saturation.
    load_setting(X_MAX, X_MAX, X_MAX, X_MAX, 16'hFFFF);
    send_bracket(X_MAX, X_MAX);
    send_bracket(X_MIN, X_MAX);
    send_bracket('0, X_MAX);
    wait_drained();
    load_setting(X_MIN, X_MIN, X_MIN, X_MIN, crb_pkg::TOLW'(1));
    send_bracket(X_MIN, X_MIN);
    send_bracket(X_MIN, X_MAX);
    wait_drained();

    // Random settings; most brackets straddle a sign change of the cubic.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_setting(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_tol());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          tries = 0;
          do begin
            a = narrow_x(NARROW_SPAN);
            b = narrow_x(NARROW_SPAN);
            tries++;
          end while (tries < 8 && sign_of(cubic_at(sx24(a))) == sign_of(cubic_at(sx24(b))));
          if ($signed(a) > $signed(b)) begin
            t = a;
            a = b;
            b = t;
          end
        end else if (kind < 9) begin
          a = crb_pkg::XW'($urandom());
          b = crb_pkg::XW'($urandom());
        end else begin
          a = crb_pkg::XW'($urandom());
          b = a;
        end
        send_bracket(a, b);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (predicted_roots.size() != 0) begin
      $error("%0d expected results never arrived", predicted_roots.size());
      mismatches++;
    end
    $display("Searched %0d brackets under %0d register settings.", items_queued,
             settings_used);
    $display("%0d results compared, %0d of them stopped by the iteration cap.",
             results_seen, cap_hits);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/crb_pkg.sv
rtl/crb_dp.sv
rtl/crb_ctrl.sv
rtl/cubic_root_bisection_core.sv
tb/sv/testbench.sv
